// ----- src/tdp_pkg.sv -----
// ----------------------------------------------------------------------------
// tdp_pkg
// Shared widths, codes and counter helpers for the tournament direction
// predictor.
// ----------------------------------------------------------------------------
package tdp_pkg;

  // Fixed field widths of the request and response items
  localparam int ADDR_W    = 64;
  localparam int IDX_OUT_W = 12;
  localparam int CNT_W     = 2;

  // Item function codes
  localparam logic FUNC_PREDICT = 1'b0;
  localparam logic FUNC_UPDATE  = 1'b1;

  // Configuration port
  localparam int               CFG_ADDR_W        = 2;
  localparam int               CFG_DATA_W        = 32;
  localparam [CFG_ADDR_W-1:0]  REG_HISTORY_XOR   = 2'd0;
  localparam logic             HISTORY_XOR_RESET = 1'b1;

  // Address fold for the bimodal and meta indices
  localparam int HASH_SHIFT = 16;

  // Saturating counter limits and the base of the alternating reset pattern
  localparam logic [CNT_W-1:0] CNT_MAX        = 2'd3;
  localparam logic [CNT_W-1:0] CNT_MIN        = 2'd0;
  localparam logic [CNT_W-1:0] CNT_RESET_BASE = 2'd1;

  // Step a 2-bit counter toward taken (up) or not taken, saturating
  function automatic logic [CNT_W-1:0] step_counter(input logic [CNT_W-1:0] c,
                                                    input logic up);
    logic [CNT_W-1:0] r;
    r = c;
    if (up) begin
      if (c != CNT_MAX) r = c + CNT_W'(1);
    end else begin
      if (c != CNT_MIN) r = c - CNT_W'(1);
    end
    return r;
  endfunction

  // Counter value of two or more reads as taken
  function automatic logic cnt_taken(input logic [CNT_W-1:0] c);
    return c[CNT_W-1];
  endfunction

endpackage

// ----- src/tdp_ifs.sv -----
// ----------------------------------------------------------------------------
// tdp_ifs
// Valid/ready channels of the predictor: request items in, response items out.
// ----------------------------------------------------------------------------
interface tdp_req_if import tdp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic                 is_conditional;
  logic [ADDR_W-1:0]    branch_addr;
  logic [ADDR_W-1:0]    target_addr;
  logic [IDX_OUT_W-1:0] saved_bimodal_index;
  logic [IDX_OUT_W-1:0] saved_pattern_index;
  logic [IDX_OUT_W-1:0] saved_meta_index;
  logic                 saved_bimodal_pred;
  logic                 saved_pattern_pred;

  modport source (
    output valid, func, is_conditional, branch_addr, target_addr,
           saved_bimodal_index, saved_pattern_index, saved_meta_index,
           saved_bimodal_pred, saved_pattern_pred,
    input  ready
  );

  modport sink (
    input  valid, func, is_conditional, branch_addr, target_addr,
           saved_bimodal_index, saved_pattern_index, saved_meta_index,
           saved_bimodal_pred, saved_pattern_pred,
    output ready
  );
endinterface

interface tdp_rsp_if import tdp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 predicted_taken;
  logic [ADDR_W-1:0]    next_addr;
  logic [IDX_OUT_W-1:0] bimodal_index;
  logic [IDX_OUT_W-1:0] pattern_index;
  logic [IDX_OUT_W-1:0] meta_index;
  logic                 bimodal_pred;
  logic                 pattern_pred;
  logic                 chose_pattern;

  modport source (
    output valid, predicted_taken, next_addr, bimodal_index, pattern_index,
           meta_index, bimodal_pred, pattern_pred, chose_pattern,
    input  ready
  );

  modport sink (
    input  valid, predicted_taken, next_addr, bimodal_index, pattern_index,
           meta_index, bimodal_pred, pattern_pred, chose_pattern,
    output ready
  );
endinterface

// ----- src/tdp_ram.sv -----
// ----------------------------------------------------------------------------
// tdp_ram
// Simple dual-port RAM with registered read and write-through forwarding of a
// write that lands on the address read in the same cycle.
// ----------------------------------------------------------------------------
module tdp_ram #(
  parameter int IDX_W  = 12,
  parameter int DATA_W = 2
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [DATA_W-1:0] wr_data
);

  localparam int DEPTH = 2 ** IDX_W;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic              fwd;
  logic [DATA_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q     <= mem[rd_idx];
      fwd      <= wr_en && (wr_idx == rd_idx);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd ? fwd_data : rd_q;

endmodule

// ----- src/tournament_direction_predictor.sv -----
// ----------------------------------------------------------------------------
// tournament_direction_predictor
// Combining branch direction predictor: bimodal, two-level pattern and meta
// chooser tables of 2-bit saturating counters, with a global history file.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake             carries
//   -------  ---  --------------------  --------------------------------------
//   req      in   valid/ready           predict or update item
//   rsp      out  valid/ready           one result item per predict item
//   apb      in   psel/penable, pready  history_xor register (address 0)
//
// One item is accepted every cycle unless the pipeline is held or clearing runs;
// a predict item's result becomes valid after the history read at the accepting
// edge, the counter read and the result register.
// After reset a clearing pass sweeps all tables and the history file, one
// entry per cycle, over 2**CLR_W indices (4096 with the default sizes); req is
// not ready during the sweep, configuration writes are taken as ever.
// A stalled result register holds the pipeline only while a predict item waits
// in the last stage; update items and bubbles keep moving.
//
module tournament_direction_predictor import tdp_pkg::*; #(
  parameter int BIMODAL_ENTRIES   = 4096,
  parameter int META_ENTRIES      = 4096,
  parameter int PATTERN_ENTRIES   = 4096,
  parameter int HISTORY_REG_COUNT = 1,
  parameter int HISTORY_BITS      = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  tdp_req_if.sink               req,
  tdp_rsp_if.source             rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Index widths: floor(log2(entries))
  localparam int BI_W      = $clog2(BIMODAL_ENTRIES + 1) - 1;
  localparam int MI_W      = $clog2(META_ENTRIES + 1) - 1;
  localparam int PI_W      = $clog2(PATTERN_ENTRIES + 1) - 1;
  localparam int HSEL_BITS = $clog2(HISTORY_REG_COUNT + 1) - 1;
  // A single history register still gets a one-bit select, masked to zero
  localparam int HSEL_W    = (HSEL_BITS > 0) ? HSEL_BITS : 1;
  localparam logic [HSEL_W-1:0] HSEL_MASK = HSEL_W'((1 << HSEL_BITS) - 1);

  localparam int MAX_BM  = (BI_W > MI_W) ? BI_W : MI_W;
  localparam int MAX_BMP = (MAX_BM > PI_W) ? MAX_BM : PI_W;
  localparam int CLR_W   = (MAX_BMP > HSEL_W) ? MAX_BMP : HSEL_W;

  typedef struct packed {
    logic                 func;
    logic                 cond;
    logic [ADDR_W-1:0]    baddr;
    logic [ADDR_W-1:0]    taddr;
    logic [IDX_OUT_W-1:0] sbi;
    logic [IDX_OUT_W-1:0] spi;
    logic [IDX_OUT_W-1:0] smi;
    logic                 sbp;
    logic                 spp;
    logic [HSEL_W-1:0]    hsel;
  } s1_t;

  typedef struct packed {
    logic              func;
    logic              cond;
    logic [ADDR_W-1:0] baddr;
    logic [ADDR_W-1:0] taddr;
    logic [BI_W-1:0]   bi;
    logic [PI_W-1:0]   pi;
    logic [MI_W-1:0]   mi;
    logic              sbp;
    logic              spp;
    logic              taken;
  } s2_t;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic history_xor;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_xor <= HISTORY_XOR_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_HISTORY_XOR) begin
      history_xor <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == REG_HISTORY_XOR) ? CFG_DATA_W'(history_xor) : '0;

  // --------------------------------------------------------------------------
  // Clearing pass after reset
  // --------------------------------------------------------------------------
  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;
  logic [CNT_W-1:0] clr_cnt_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + CLR_W'(1);
      if (clr_cnt == '1) clearing <= 1'b0;
    end
  end

  // Entry i resets to (i & 1) + 1: weak not taken / weak taken alternating
  assign clr_cnt_val = {1'b0, clr_cnt[0]} + CNT_RESET_BASE;

  // --------------------------------------------------------------------------
  // Pipeline control
  // --------------------------------------------------------------------------
  logic s1_v, s2_v, out_v;
  s1_t  s1;
  s2_t  s2;
  logic s2_res;
  logic advance;
  logic load_out;

  assign s2_res   = s2_v && (s2.func == FUNC_PREDICT);
  // Hold everything only when a result sits in the last stage with nowhere to go
  assign advance  = !(s2_res && out_v && !rsp.ready);
  assign load_out = advance && s2_res;
  assign req.ready = advance && !clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      out_v <= 1'b0;
    end else begin
      if (advance) begin
        s1_v <= req.valid && req.ready;
        s2_v <= s1_v;
      end
      if (load_out) out_v <= 1'b1;
      else if (rsp.ready) out_v <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: input register and history read
  // --------------------------------------------------------------------------
  logic [HSEL_W-1:0]       req_hsel;
  logic [HISTORY_BITS-1:0] hist_q;
  logic                    s1_taken;
  logic                    hist_wr_en;
  logic [HSEL_W-1:0]       hist_wr_idx;
  logic [HISTORY_BITS-1:0] hist_wr_data;

  assign req_hsel = req.branch_addr[HSEL_W-1:0] & HSEL_MASK;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1.func  <= req.func;
      s1.cond  <= req.is_conditional;
      s1.baddr <= req.branch_addr;
      s1.taddr <= req.target_addr;
      s1.sbi   <= req.saved_bimodal_index;
      s1.spi   <= req.saved_pattern_index;
      s1.smi   <= req.saved_meta_index;
      s1.sbp   <= req.saved_bimodal_pred;
      s1.spp   <= req.saved_pattern_pred;
      s1.hsel  <= req_hsel;
    end
  end

  // Resolved direction: any target address other than the branch address is taken
  assign s1_taken = (s1.taddr != s1.baddr);

  // Shift the outcome into history as a conditional update leaves stage 1
  always_comb begin
    if (clearing) begin
      hist_wr_en   = 1'b1;
      hist_wr_idx  = clr_cnt[HSEL_W-1:0];
      hist_wr_data = '0;
    end else begin
      hist_wr_en   = advance && s1_v && (s1.func == FUNC_UPDATE) && s1.cond;
      hist_wr_idx  = s1.hsel;
      hist_wr_data = HISTORY_BITS'({hist_q, s1_taken});
    end
  end

  tdp_ram #(.IDX_W(HSEL_W), .DATA_W(HISTORY_BITS)) u_hist (
    .clk     (clk),
    .rd_en   (advance),
    .rd_idx  (req_hsel),
    .rd_data (hist_q),
    .wr_en   (hist_wr_en),
    .wr_idx  (hist_wr_idx),
    .wr_data (hist_wr_data)
  );

  // --------------------------------------------------------------------------
  // Stage 1 index selection: hashed on predict, saved on update
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0] hash64;
  logic [ADDR_W-1:0] pat64;
  logic [BI_W-1:0]   s1_bi;
  logic [PI_W-1:0]   s1_pi;
  logic [MI_W-1:0]   s1_mi;

  always_comb begin
    hash64 = (s1.baddr >> HASH_SHIFT) ^ s1.baddr;
    if (history_xor) pat64 = ADDR_W'(hist_q) ^ s1.baddr;
    else             pat64 = ADDR_W'(hist_q) | (s1.baddr << HISTORY_BITS);
    if (s1.func == FUNC_UPDATE) begin
      s1_bi = BI_W'(ADDR_W'(s1.sbi));
      s1_pi = PI_W'(ADDR_W'(s1.spi));
      s1_mi = MI_W'(ADDR_W'(s1.smi));
    end else begin
      s1_bi = BI_W'(hash64);
      s1_pi = PI_W'(pat64);
      s1_mi = MI_W'(hash64);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2.func  <= s1.func;
      s2.cond  <= s1.cond;
      s2.baddr <= s1.baddr;
      s2.taddr <= s1.taddr;
      s2.bi    <= s1_bi;
      s2.pi    <= s1_pi;
      s2.mi    <= s1_mi;
      s2.sbp   <= s1.sbp;
      s2.spp   <= s1.spp;
      s2.taken <= s1_taken;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: counter tables, read-modify-write on update
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0] cnt_b, cnt_p, cnt_m;
  logic             upd_s2;
  logic             wr_b_en, wr_p_en, wr_m_en;
  logic [BI_W-1:0]  wr_b_idx;
  logic [PI_W-1:0]  wr_p_idx;
  logic [MI_W-1:0]  wr_m_idx;
  logic [CNT_W-1:0] wr_b_data, wr_p_data, wr_m_data;

  assign upd_s2 = advance && s2_v && (s2.func == FUNC_UPDATE) && s2.cond;

  always_comb begin
    if (clearing) begin
      wr_b_en   = 1'b1;
      wr_p_en   = 1'b1;
      wr_m_en   = 1'b1;
      wr_b_idx  = clr_cnt[BI_W-1:0];
      wr_p_idx  = clr_cnt[PI_W-1:0];
      wr_m_idx  = clr_cnt[MI_W-1:0];
      wr_b_data = clr_cnt_val;
      wr_p_data = clr_cnt_val;
      wr_m_data = clr_cnt_val;
    end else begin
      wr_b_en   = upd_s2;
      wr_p_en   = upd_s2;
      // Train the chooser only when the two tables disagreed
      wr_m_en   = upd_s2 && (s2.sbp != s2.spp);
      wr_b_idx  = s2.bi;
      wr_p_idx  = s2.pi;
      wr_m_idx  = s2.mi;
      wr_b_data = step_counter(cnt_b, s2.taken);
      wr_p_data = step_counter(cnt_p, s2.taken);
      wr_m_data = step_counter(cnt_m, s2.spp == s2.taken);
    end
  end

  tdp_ram #(.IDX_W(BI_W), .DATA_W(CNT_W)) u_bimodal (
    .clk     (clk),
    .rd_en   (advance),
    .rd_idx  (s1_bi),
    .rd_data (cnt_b),
    .wr_en   (wr_b_en),
    .wr_idx  (wr_b_idx),
    .wr_data (wr_b_data)
  );

  tdp_ram #(.IDX_W(PI_W), .DATA_W(CNT_W)) u_pattern (
    .clk     (clk),
    .rd_en   (advance),
    .rd_idx  (s1_pi),
    .rd_data (cnt_p),
    .wr_en   (wr_p_en),
    .wr_idx  (wr_p_idx),
    .wr_data (wr_p_data)
  );

  tdp_ram #(.IDX_W(MI_W), .DATA_W(CNT_W)) u_meta (
    .clk     (clk),
    .rd_en   (advance),
    .rd_idx  (s1_mi),
    .rd_data (cnt_m),
    .wr_en   (wr_m_en),
    .wr_idx  (wr_m_idx),
    .wr_data (wr_m_data)
  );

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic bp, pp, cp, taken;

  assign bp    = cnt_taken(cnt_b);
  assign pp    = cnt_taken(cnt_p);
  assign cp    = cnt_taken(cnt_m);
  assign taken = cp ? pp : bp;

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (s2.cond) begin
        rsp.predicted_taken <= taken;
        rsp.next_addr       <= taken ? s2.taddr : s2.baddr;
        rsp.bimodal_index   <= IDX_OUT_W'(ADDR_W'(s2.bi));
        rsp.pattern_index   <= IDX_OUT_W'(ADDR_W'(s2.pi));
        rsp.meta_index      <= IDX_OUT_W'(ADDR_W'(s2.mi));
        rsp.bimodal_pred    <= bp;
        rsp.pattern_pred    <= pp;
        rsp.chose_pattern   <= cp;
      end else begin
        // Unconditional: pass the target, no table lookup reported
        rsp.predicted_taken <= 1'b1;
        rsp.next_addr       <= s2.taddr;
        rsp.bimodal_index   <= '0;
        rsp.pattern_index   <= '0;
        rsp.meta_index      <= '0;
        rsp.bimodal_pred    <= 1'b0;
        rsp.pattern_pred    <= 1'b0;
        rsp.chose_pattern   <= 1'b0;
      end
    end
  end

  assign rsp.valid = out_v;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_accept_enters_s1 : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> s1_v)
    else $error("accepted item did not enter stage 1");

  a_predict_gives_result : assert property (@(posedge clk) disable iff (rst)
    load_out |=> rsp.valid)
    else $error("predict item left stage 2 without a result");

  a_clear_done_stays : assert property (@(posedge clk) disable iff (rst)
    !clearing |=> !clearing)
    else $error("clearing pass restarted without reset");

  a_no_update_write_in_clear : assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(s1_v || s2_v))
    else $error("item in flight during clearing pass");

endmodule
